// File: rtl/core/assert_macros.svh
// assertion macros used by the websocket frame builder rtl
// simulation builds get the checks, synthesis builds get empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/core/wsfb_pkg.sv
`timescale 1ns / 1ps
// constants and codes for the websocket frame builder
// no dependencies
package wsfb_pkg;

  localparam int HDR_MAX_BYTES = 14;
  localparam int HDR_W         = HDR_MAX_BYTES * 8;
  localparam int HDR_CNT_W     = $clog2(HDR_MAX_BYTES + 1);
  localparam int LEN_W         = 63;
  localparam int KEY_W         = 32;

  localparam logic [HDR_CNT_W-1:0] HDR_BYTES_SHORT = HDR_CNT_W'(6);
  localparam logic [HDR_CNT_W-1:0] HDR_BYTES_MID   = HDR_CNT_W'(8);
  localparam logic [HDR_CNT_W-1:0] HDR_BYTES_LONG  = HDR_CNT_W'(HDR_MAX_BYTES);

  localparam logic [7:0] HDR_FIN_TEXT = 8'h81;
  localparam logic [7:0] MASK_BIT     = 8'h80;
  localparam logic [7:0] LEN_ESC16    = 8'd126;
  localparam logic [7:0] LEN_ESC64    = 8'd127;

  localparam logic [LEN_W-1:0] LEN7_MAX  = LEN_W'(125);
  localparam logic [LEN_W-1:0] LEN16_MAX = LEN_W'(65535);

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_DROPPED = 1'b1;

endpackage

// File: rtl/core/websocket_frame_builder.sv
`timescale 1ns / 1ps
// Masked client text frame builder. A start word (operation 0) takes the
// message length and masking key and produces the frame header: 6 bytes for
// lengths up to 125, 8 bytes up to 65535, 14 bytes above. The header is
// loaded into one shift register and one byte leaves per cycle while the
// output is not stalled, so a start word holds the input stalled until the
// last header byte has been loaded. A payload word (operation 1) produces
// one masked byte; surplus payload words beyond the declared length come
// back as a single byte 0 with status set. The output word sits in a
// register, so a new word is taken while the last result waits only when
// that register is free or being drained.
// depends on wsfb_pkg and assert_macros.svh
`include "assert_macros.svh"

module websocket_frame_builder
  import wsfb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             operation,
  input  logic [7:0]       payload_byte,
  input  logic [LEN_W-1:0] message_length,
  input  logic [KEY_W-1:0] mask_key,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       frame_byte,
  output logic             end_of_run,
  output logic             end_of_frame,
  output logic             status
);

  typedef enum logic [0:0] {S_IDLE, S_HDR} state_t;

  state_t               state;
  logic [HDR_W-1:0]     hdr_sr;
  logic [HDR_CNT_W-1:0] hdr_cnt;
  logic                 hdr_empty;
  logic [KEY_W-1:0]     key_store;
  logic [1:0]           key_phase;
  logic [LEN_W-1:0]     bytes_left;

  logic                 out_free;
  logic                 in_accept;
  logic                 out_load;
  logic [HDR_W-1:0]     hdr_load;
  logic [HDR_CNT_W-1:0] hdr_len;
  logic [7:0]           key_byte;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  // a new output word is loaded this cycle
  assign out_load  = (state == S_IDLE) ? (in_accept && operation == OP_PAYLOAD) : out_free;

  // header image, first wire byte in the top bits
  always_comb begin
    if (message_length <= LEN7_MAX) begin
      hdr_load = {HDR_FIN_TEXT, MASK_BIT | {1'b0, message_length[6:0]}, mask_key, 64'h0};
      hdr_len  = HDR_BYTES_SHORT;
    end else if (message_length <= LEN16_MAX) begin
      hdr_load = {HDR_FIN_TEXT, MASK_BIT | LEN_ESC16, message_length[15:0], mask_key,
                  48'h0};
      hdr_len  = HDR_BYTES_MID;
    end else begin
      hdr_load = {HDR_FIN_TEXT, MASK_BIT | LEN_ESC64, 1'b0, message_length, mask_key};
      hdr_len  = HDR_BYTES_LONG;
    end
  end

  always_comb begin
    unique case (key_phase)
      2'd0:    key_byte = key_store[31:24];
      2'd1:    key_byte = key_store[23:16];
      2'd2:    key_byte = key_store[15:8];
      default: key_byte = key_store[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      hdr_cnt    <= '0;
      hdr_empty  <= 1'b0;
      key_store  <= '0;
      key_phase  <= '0;
      bytes_left <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (operation == OP_START) begin
              hdr_sr     <= hdr_load;
              hdr_cnt    <= hdr_len;
              hdr_empty  <= (message_length == '0);
              key_store  <= mask_key;
              key_phase  <= '0;
              bytes_left <= message_length;
              state      <= S_HDR;
            end else begin
              end_of_run <= 1'b1;
              if (bytes_left == '0) begin
                frame_byte   <= 8'h00;
                end_of_frame <= 1'b0;
                status       <= ST_DROPPED;
              end else begin
                frame_byte   <= payload_byte ^ key_byte;
                end_of_frame <= (bytes_left == LEN_W'(1));
                status       <= ST_OK;
                key_phase    <= key_phase + 2'd1;
                bytes_left   <= bytes_left - LEN_W'(1);
              end
            end
          end
        end
        S_HDR: begin
          if (out_free) begin
            frame_byte   <= hdr_sr[HDR_W-1 -: 8];
            hdr_sr       <= {hdr_sr[HDR_W-9:0], 8'h00};
            hdr_cnt      <= hdr_cnt - HDR_CNT_W'(1);
            end_of_run   <= (hdr_cnt == HDR_CNT_W'(1));
            end_of_frame <= (hdr_cnt == HDR_CNT_W'(1)) && hdr_empty;
            status       <= ST_OK;
            if (hdr_cnt == HDR_CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_hdr_cnt_live, clk, rst, state == S_HDR, hdr_cnt != '0,
                  "header count empty while sending header")
  `ASSERT_IMPLIES(a_drop_form, clk, rst, out_valid && status == ST_DROPPED,
                  end_of_run && !end_of_frame, "dropped word not a lone result")
  `ASSERT_IMPLIES(a_eof_ends_run, clk, rst, out_valid && end_of_frame, end_of_run,
                  "frame end without run end")
  `ASSERT_NEXT(a_start_to_hdr, clk, rst, in_accept && operation == OP_START,
               state == S_HDR, "start word did not begin header")
  `ASSERT_NEXT(a_payload_one_word, clk, rst, in_accept && operation == OP_PAYLOAD,
               out_valid && end_of_run, "payload word gave no result")

endmodule

// File: verif/tb_websocket_frame_builder.sv
`timescale 1ns / 1ps
// self-checking testbench for websocket_frame_builder: directed and random words,
// every frame byte predicted in the testbench and compared as it leaves the block
// depends on wsfb_pkg and the websocket_frame_builder rtl
module tb_websocket_frame_builder;
  import wsfb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_WORDS  = 410;
  localparam int IDLE_PCT      = 11;
  localparam int DRAIN_CYCLES  = 20;

  typedef struct {
    logic [7:0] frame_byte;
    logic       end_of_run;
    logic       end_of_frame;
    logic       status;
  } wire_byte_t;

  // predicts the frame bytes of each accepted word and checks them in order
  class frame_byte_scoreboard;
    logic [KEY_W-1:0] key_store;
    logic [1:0]       key_phase;
    logic [LEN_W-1:0] bytes_left;
    wire_byte_t       pending_bytes[$];
    int errors;
    int n_words, n_short, n_mid, n_long, n_payload, n_dropped, n_checked;

    function new();
      key_store  = '0;
      key_phase  = '0;
      bytes_left = '0;
      errors     = 0;
      n_words    = 0;
      n_short    = 0;
      n_mid      = 0;
      n_long     = 0;
      n_payload  = 0;
      n_dropped  = 0;
      n_checked  = 0;
    endfunction

    function void push_byte(logic [7:0] b, logic eor, logic eof, logic st);
      wire_byte_t w;
      w.frame_byte   = b;
      w.end_of_run   = eor;
      w.end_of_frame = eof;
      w.status       = st;
      pending_bytes.push_back(w);
    endfunction

    function void note_word(logic op, logic [7:0] pb, logic [LEN_W-1:0] len,
                            logic [KEY_W-1:0] key);
      logic [7:0]  hdr[$];
      logic [63:0] len64;
      logic [7:0]  kb;
      logic        last;
      n_words++;
      if (op == OP_START) begin
        len64 = {1'b0, len};
        hdr.push_back(HDR_FIN_TEXT);
        if (len <= LEN7_MAX) begin
          hdr.push_back(MASK_BIT | len[7:0]);
          n_short++;
        end else if (len <= LEN16_MAX) begin
          hdr.push_back(MASK_BIT | LEN_ESC16);
          hdr.push_back(len[15:8]);
          hdr.push_back(len[7:0]);
          n_mid++;
        end else begin
          hdr.push_back(MASK_BIT | LEN_ESC64);
          for (int i = 7; i >= 0; i--) hdr.push_back(len64[8*i +: 8]);
          n_long++;
        end
        for (int i = 3; i >= 0; i--) hdr.push_back(key[8*i +: 8]);
        key_store  = key;
        key_phase  = '0;
        bytes_left = len;
        foreach (hdr[i]) begin
          last = (i == hdr.size() - 1);
          push_byte(hdr[i], last, last && (len == '0), ST_OK);
        end
      end else if (bytes_left == '0) begin
        n_dropped++;
        push_byte(8'h00, 1'b1, 1'b0, ST_DROPPED);
      end else begin
        n_payload++;
        kb = key_store[8*(3 - key_phase) +: 8];
        key_phase++;
        bytes_left--;
        push_byte(pb ^ kb, 1'b1, bytes_left == '0, ST_OK);
      end
    endfunction

    function void check_byte(logic [7:0] b, logic eor, logic eof, logic st);
      wire_byte_t w;
      n_checked++;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte %02h eor %0b eof %0b status %0b",
                 $time, b, eor, eof, st);
        errors++;
        return;
      end
      w = pending_bytes.pop_front();
      if (b !== w.frame_byte) begin
        $display("%0t: frame_byte expected %02h actual %02h", $time, w.frame_byte, b);
        errors++;
      end
      if (eor !== w.end_of_run) begin
        $display("%0t: end_of_run expected %0b actual %0b", $time, w.end_of_run, eor);
        errors++;
      end
      if (eof !== w.end_of_frame) begin
        $display("%0t: end_of_frame expected %0b actual %0b", $time, w.end_of_frame, eof);
        errors++;
      end
      if (st !== w.status) begin
        $display("%0t: status expected %0b actual %0b", $time, w.status, st);
        errors++;
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic             operation;
  logic [7:0]       payload_byte;
  logic [LEN_W-1:0] message_length;
  logic [KEY_W-1:0] mask_key;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       frame_byte;
  logic             end_of_run;
  logic             end_of_frame;
  logic             status;

  frame_byte_scoreboard sb;
  bit quiet;
  int cycles = 0;

  websocket_frame_builder i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .payload_byte  (payload_byte),
    .message_length(message_length),
    .mask_key      (mask_key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .end_of_run    (end_of_run),
    .end_of_frame  (end_of_frame),
    .status        (status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycles, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // output side: check accepted bytes, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_byte(frame_byte, end_of_run, end_of_frame, status);
    if (rst)
      out_stall <= 1'b0;
    else
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic send_word(input logic op, input logic [7:0] pb,
                           input logic [LEN_W-1:0] len, input logic [KEY_W-1:0] key);
    while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    payload_byte   <= pb;
    message_length <= len;
    mask_key       <= key;
    do @(posedge clk); while (in_stall);
    sb.note_word(op, pb, len, key);
  endtask

  // payload word with don't-care length and key fields randomized
  task automatic send_payload(input logic [7:0] pb);
    send_word(OP_PAYLOAD, pb, LEN_W'({$urandom, $urandom}), $urandom);
  endtask

  task automatic send_start(input logic [LEN_W-1:0] len, input logic [KEY_W-1:0] key);
    send_word(OP_START, 8'($urandom_range(255)), len, key);
  endtask

  initial begin
    logic [LEN_W-1:0] len;
    int               n_send;
    int               sel;
    int               word_cnt;
    sb             = new();
    quiet          = 1'b0;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    operation      <= OP_START;
    payload_byte   <= '0;
    message_length <= '0;
    mask_key       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: surplus after reset, empty message, length boundaries, key extremes
    send_payload(8'hff);
    send_start('0, 32'hffff_ffff);
    send_payload(8'h00);
    send_start(LEN_W'(1), 32'h0000_0000);
    send_payload(8'hff);
    send_start(LEN7_MAX, 32'ha5c3_0f81);
    send_payload(8'h00);
    send_payload(8'hff);
    send_payload(8'h5a);
    send_payload(8'h3c);
    send_payload(8'h96);
    send_start(LEN_W'(126), 32'h1234_5678);
    send_payload(8'h01);
    send_start(LEN16_MAX, 32'h8000_0001);
    send_payload(8'h80);
    send_start(LEN_W'(65536), 32'hdead_beef);
    send_start({LEN_W{1'b1}}, 32'hffff_ffff);
    send_payload(8'hff);
    send_start(LEN_W'(3), 32'h0102_0304);
    send_payload(8'h10);
    send_payload(8'h20);
    send_payload(8'h30);
    send_payload(8'h40);

    // random: mostly well-formed messages, some truncated, surplus bytes and noise
    word_cnt = 0;
    while (word_cnt < RANDOM_WORDS) begin
      quiet = (word_cnt >= 180) && (word_cnt < 260);
      sel = $urandom_range(99);
      if (sel < 5) begin
        send_payload(8'($urandom_range(255)));
        word_cnt++;
        continue;
      end
      sel = $urandom_range(99);
      if (sel < 60)      len = LEN_W'($urandom_range(12));
      else if (sel < 80) len = LEN_W'($urandom_range(125, 13));
      else if (sel < 90) len = LEN_W'($urandom_range(65535, 126));
      else begin
        len = LEN_W'({$urandom, $urandom});
        if (len <= LEN16_MAX) len = len + LEN_W'(65536);
      end
      send_start(len, $urandom);
      word_cnt++;
      // long messages get cut short and abandoned by the next start
      n_send = (len > 16) ? $urandom_range(16) : int'(len);
      for (int i = 0; i < n_send; i++) send_payload(8'($urandom_range(255)));
      word_cnt += n_send;
      if (len == LEN_W'(n_send) && $urandom_range(99) < 20) begin
        n_send = $urandom_range(2, 1);
        for (int i = 0; i < n_send; i++) send_payload(8'($urandom_range(255)));
        word_cnt += n_send;
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("words: %0d (headers %0d short, %0d mid, %0d long; %0d payload, %0d dropped)",
             sb.n_words, sb.n_short, sb.n_mid, sb.n_long, sb.n_payload, sb.n_dropped);
    $display("frame bytes checked: %0d, mismatches: %0d", sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: websocket_frame_builder.f
+incdir+rtl/core
rtl/core/wsfb_pkg.sv
rtl/core/websocket_frame_builder.sv
verif/tb_websocket_frame_builder.sv
